// ===== rtl/tcos_pkg.sv =====
// Shared types, widths, term tables and the term accumulate function for the cosine series.
package tcos_pkg;

   localparam int MAX_TERMS = 16;
   localparam int FRAC_BITS = 24;

   localparam int ANGLE_W = 27;
   localparam int COUNT_W = 5;
   localparam int PREC_W  = 25;
   localparam int COS_W   = 32;
   localparam int USED_W  = $clog2(MAX_TERMS + 1);
   localparam int TIDX_W  = $clog2(MAX_TERMS);

   localparam int AX_W      = ANGLE_W;
   localparam int SQ_W      = 2 * AX_W;
   localparam int X2_W      = 29;
   localparam int MAG_W     = 29;
   localparam int NUM_W     = MAG_W + X2_W;
   localparam int Z_W       = 33;
   localparam int RCP_W     = 33;
   localparam int RCP_SHIFT = 33;
   localparam int DEN_W     = 10;
   localparam int SUM_W     = 34;

   typedef logic [MAG_W-1:0] mag_type;

   typedef enum logic {
      MODE_FIXED,
      MODE_PRECISION
   } mode_type;

   typedef struct packed {
      mode_type                  mode;
      logic [X2_W-1:0]           x2;
      logic [COUNT_W-1:0]        count;
      logic [PREC_W-1:0]         prec;
      logic signed [SUM_W-1:0]   sum;
      logic [USED_W-1:0]         used;
      logic                      done;
   } item_type;

   // (2k-1)(2k)
   function automatic logic [DEN_W-1:0] term_den(input logic [TIDX_W-1:0] k);
      logic [DEN_W-1:0] tk;
      tk = DEN_W'({k, 1'b0});
      return DEN_W'((tk - DEN_W'(1)) * tk);
   endfunction

   // floor(2^33 / ((2k-1)(2k)))
   function automatic logic [RCP_W-1:0] term_recip(input logic [TIDX_W-1:0] k);
      logic [RCP_W-1:0] r;
      case (k)
         TIDX_W'(1):  r = RCP_W'(64'd4294967296);
         TIDX_W'(2):  r = RCP_W'(64'd715827882);
         TIDX_W'(3):  r = RCP_W'(64'd286331153);
         TIDX_W'(4):  r = RCP_W'(64'd153391689);
         TIDX_W'(5):  r = RCP_W'(64'd95443717);
         TIDX_W'(6):  r = RCP_W'(64'd65075262);
         TIDX_W'(7):  r = RCP_W'(64'd47197442);
         TIDX_W'(8):  r = RCP_W'(64'd35791394);
         TIDX_W'(9):  r = RCP_W'(64'd28071681);
         TIDX_W'(10): r = RCP_W'(64'd22605091);
         TIDX_W'(11): r = RCP_W'(64'd18592932);
         TIDX_W'(12): r = RCP_W'(64'd15561475);
         TIDX_W'(13): r = RCP_W'(64'd13215283);
         TIDX_W'(14): r = RCP_W'(64'd11362347);
         TIDX_W'(15): r = RCP_W'(64'd9873488);
         default:     r = '0;
      endcase
      return r;
   endfunction

   function automatic item_type add_term(input item_type it, input mag_type mag,
                                         input logic [TIDX_W-1:0] k);
      item_type                r;
      logic                    active;
      logic signed [SUM_W-1:0] term;
      r    = it;
      term = SUM_W'(signed'({1'b0, mag}));
      if (it.mode == MODE_FIXED) begin
         active = USED_W'(k) < USED_W'(it.count);
      end else begin
         active = !it.done;
      end
      if (active) begin
         r.sum  = k[0] ? it.sum - term : it.sum + term;
         r.used = USED_W'(k) + USED_W'(1);
         if (it.mode == MODE_PRECISION) begin
            r.done = mag < MAG_W'(it.prec);
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/tcos_cell.sv =====
// One series cell: adds the incoming term and derives the next term magnitude in three stages.
module tcos_cell import tcos_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [TIDX_W-1:0] cell_index,
   input  logic              in_valid,
   input  item_type          in_item,
   input  mag_type           in_mag,
   output logic              out_valid,
   output item_type          out_item,
   output mag_type           out_mag
);

   logic               v1_ff, v1_in;
   item_type           item1_ff, item1_in;
   logic [NUM_W-1:0]   num1_ff, num1_in;

   logic               v2_ff, v2_in;
   item_type           item2_ff;
   logic [Z_W-1:0]     z2_ff, z2_in;
   mag_type            q2_ff, q2_in;

   logic               v3_ff, v3_in;
   item_type           item3_ff;
   mag_type            mag3_ff, mag3_in;

   logic [DEN_W-1:0]       den;
   logic [RCP_W-1:0]       rcp;
   logic [NUM_W:0]         zsum;
   logic [Z_W+RCP_W-1:0]   qprod;
   logic [Z_W:0]           qd;
   logic [Z_W:0]           rem;

   assign den = term_den(cell_index);
   assign rcp = term_recip(cell_index);

   always_comb begin
      v1_in    = in_valid;
      item1_in = add_term(in_item, in_mag, cell_index - TIDX_W'(1));
      num1_in  = in_mag * in_item.x2;
   end

   always_comb begin
      v2_in = v1_ff;
      zsum  = {1'b0, num1_ff} + ((NUM_W+1)'(den) << (FRAC_BITS - 1));
      z2_in = Z_W'(zsum >> FRAC_BITS);
      qprod = z2_in * rcp;
      q2_in = MAG_W'(qprod >> RCP_SHIFT);
   end

   always_comb begin
      v3_in   = v2_ff;
      qd      = (Z_W+1)'(q2_ff) * (Z_W+1)'(den);
      rem     = {1'b0, z2_ff} - qd;
      mag3_in = (rem >= (Z_W+1)'(den)) ? q2_ff + MAG_W'(1) : q2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      item1_ff <= item1_in;
      num1_ff  <= num1_in;
      item2_ff <= item1_ff;
      z2_ff    <= z2_in;
      q2_ff    <= q2_in;
      item3_ff <= item2_ff;
      mag3_ff  <= mag3_in;
   end

   assign out_valid = v3_ff;
   assign out_item  = item3_ff;
   assign out_mag   = mag3_ff;

endmodule

// ===== rtl/taylor_cosine_approximator_top.sv =====
// Top level of the Taylor-series cosine block: request capture, x squared, cell row, result.
//
//   channel   handshake              payload
//   request   start / busy           req_operation, req_angle, req_term_count, req_precision
//   response  rsp_valid (one cycle)  rsp_cosine, rsp_terms_used, rsp_limit_reached
//
// The result beat follows the request beat through the capture, x squared, cell row and result
// registers; busy drops with rsp_valid and the next request beat can be taken at the edge that
// takes the result, so the block holds one item at a time.
// Stages: 1 capture, 1 x squared, 3 per cell (multiply, reciprocal multiply, correct)
// over 15 cells, 1 final sum and saturate.
// Synchronous reset clears busy and all valid flags; no item survives it.
// The receiver cannot stall: each result beat is shown for one cycle only.
module taylor_cosine_approximator_top import tcos_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_operation,
   input  logic signed [ANGLE_W-1:0] req_angle,
   input  logic [COUNT_W-1:0]        req_term_count,
   input  logic [PREC_W-1:0]         req_precision,
   output logic                      rsp_valid,
   output logic signed [COS_W-1:0]   rsp_cosine,
   output logic [USED_W-1:0]         rsp_terms_used,
   output logic                      rsp_limit_reached
);

   localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) << (COS_W - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) << (COS_W - 1));
   localparam int LAST = MAX_TERMS - 1;

   logic                 accept;
   logic                 busy_ff, busy_in;

   logic                 a_valid_ff, a_valid_in;
   item_type             a_item_ff, a_item_in;
   logic [AX_W-1:0]      a_ax_ff, a_ax_in;

   logic [SQ_W:0]        sq_round;
   logic [MAX_TERMS-1:0] chain_valid;
   item_type             chain_item [MAX_TERMS];
   mag_type              chain_mag  [MAX_TERMS];
   logic                 b_valid_ff;
   item_type             b_item_ff, b_item_in;

   item_type                fin;
   logic                    rsp_valid_ff;
   logic signed [COS_W-1:0] rsp_cosine_ff, rsp_cosine_in;
   logic [USED_W-1:0]       rsp_used_ff;
   logic                    rsp_limit_ff, rsp_limit_in;

   assign accept = start && !busy_ff;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (chain_valid[LAST]) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      a_valid_in     = accept;
      a_item_in      = '0;
      a_item_in.mode = mode_type'(req_operation);
      a_item_in.count = (req_term_count > COUNT_W'(MAX_TERMS)) ? COUNT_W'(MAX_TERMS)
                                                              : req_term_count;
      a_item_in.prec = req_precision;
      a_ax_in        = req_angle[ANGLE_W-1] ? AX_W'(-req_angle) : AX_W'(req_angle);
   end

   always_comb begin
      sq_round     = a_ax_ff * a_ax_ff + ((SQ_W+1)'(1) << (FRAC_BITS - 1));
      b_item_in    = a_item_ff;
      b_item_in.x2 = X2_W'(sq_round >> FRAC_BITS);
   end

   assign chain_valid[0] = b_valid_ff;
   assign chain_item[0]  = b_item_ff;
   assign chain_mag[0]   = MAG_W'(1) << FRAC_BITS;

   for (genvar i = 1; i < MAX_TERMS; i++) begin : g_cell
      tcos_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (TIDX_W'(i)),
         .in_valid   (chain_valid[i-1]),
         .in_item    (chain_item[i-1]),
         .in_mag     (chain_mag[i-1]),
         .out_valid  (chain_valid[i]),
         .out_item   (chain_item[i]),
         .out_mag    (chain_mag[i])
      );
   end

   always_comb begin
      fin = add_term(chain_item[LAST], chain_mag[LAST], TIDX_W'(LAST));
      if (fin.sum > SAT_HI) begin
         rsp_cosine_in = COS_W'(SAT_HI);
      end else if (fin.sum < SAT_LO) begin
         rsp_cosine_in = COS_W'(SAT_LO);
      end else begin
         rsp_cosine_in = COS_W'(fin.sum);
      end
      rsp_limit_in = (fin.mode == MODE_PRECISION) && !fin.done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= a_valid_ff;
         rsp_valid_ff <= chain_valid[LAST];
      end
   end

   always_ff @(posedge clock) begin
      a_item_ff     <= a_item_in;
      a_ax_ff       <= a_ax_in;
      b_item_ff     <= b_item_in;
      rsp_cosine_ff <= rsp_cosine_in;
      rsp_used_ff   <= fin.used;
      rsp_limit_ff  <= rsp_limit_in;
   end

   assign busy              = busy_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cosine        = rsp_cosine_ff;
   assign rsp_terms_used    = rsp_used_ff;
   assign rsp_limit_reached = rsp_limit_ff;

   a_busy_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result beat");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beat repeated");

   a_limit_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_limit_reached) |-> (rsp_terms_used == USED_W'(MAX_TERMS)))
      else $error("limit flagged before all terms were summed");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      $onehot0({a_valid_ff, chain_valid}))
      else $error("more than one item in the cell row");

endmodule
